### rtl/pch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pch_pkg: shared types and constants of the printable character histogram
// Item kinds, internal operation codes, queue entry and sequencer state types.
// ----------------------------------------------------------------------------
package pch_pkg;

    localparam int COUNT_WIDTH_DEF = 48;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int OUT_W           = 48;
    localparam int BIN_COUNT       = 95;
    localparam int BIN_W           = $clog2(BIN_COUNT);

    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] LAST_PRINTABLE  = 8'd126;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_ABORT = 2'd3;

    localparam logic RESP_MESSAGE  = 1'b0;
    localparam logic RESP_LIFETIME = 1'b1;

    typedef enum logic [2:0] {
        OP_DATA,
        OP_END,
        OP_QUERY,
        OP_QUERY_ZERO,
        OP_ABORT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [BIN_W-1:0] bin;
    } op_item_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_QUERY,
        ST_MERGE,
        ST_MERGE_LAST
    } state_t;

endpackage
`default_nettype wire

### rtl/pch_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pch_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered (read before write).
// ----------------------------------------------------------------------------
module pch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule
`default_nettype wire

### rtl/pch_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pch_front: input classifier
// Accepts stream transactions, maps them to operations and drops
// non-printable data bytes before they reach the queue.
// ----------------------------------------------------------------------------
module pch_front (
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic [1:0]        s_tuser,
    input  wire logic              q_full,
    output logic                   q_push,
    output pch_pkg::op_item_t      q_item
);
    import pch_pkg::*;

    logic printable;
    logic keep;

    assign printable = (s_tdata >= FIRST_PRINTABLE) && (s_tdata <= LAST_PRINTABLE);
    assign s_tready  = !q_full;

    always_comb
    begin
        q_item.bin = BIN_W'(s_tdata - FIRST_PRINTABLE);
        keep       = 1'b1;
        case (s_tuser)
            KIND_DATA:
            begin
                q_item.op = OP_DATA;
                keep      = printable;
            end
            KIND_END:   q_item.op = OP_END;
            KIND_QUERY: q_item.op = printable ? OP_QUERY : OP_QUERY_ZERO;
            KIND_ABORT: q_item.op = OP_ABORT;
            default:    q_item.op = OP_ABORT;
        endcase
    end

    assign q_push = s_tvalid && s_tready && keep;

endmodule
`default_nettype wire

### rtl/pch_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pch_fifo: operation queue
// Short register queue between the classifier and the execution unit.
// ----------------------------------------------------------------------------
module pch_fifo #(
    parameter int DEPTH = pch_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  pch_pkg::op_item_t      push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   valid,
    output pch_pkg::op_item_t      head_item
);
    import pch_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_item_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign valid     = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### rtl/pch_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pch_back: histogram execution unit
// Per-message and lifetime count memories, pipelined read-modify-write for
// data bytes, bin-by-bin merge at end of message, and the result register.
// ----------------------------------------------------------------------------
module pch_back #(
    parameter int COUNT_WIDTH = pch_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    input  pch_pkg::op_item_t              q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [pch_pkg::OUT_W-1:0]      m_tdata,   // count_value[47:0]
    output logic [0:0]                     m_tuser    // response_kind
);
    import pch_pkg::*;

    localparam int              CW        = COUNT_WIDTH;
    localparam int              EXT_W     = (CW > OUT_W) ? CW : OUT_W;
    localparam logic [CW-1:0]   COUNT_MAX = {CW{1'b1}};

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CW] ? COUNT_MAX : sum[CW-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [CW-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ext[OUT_W-1:0];
    endfunction

    state_t               state_reg, state_next;

    logic                 w_valid_reg, w_valid_next;
    logic [BIN_W-1:0]     w_bin_reg, w_bin_next;
    logic                 fwd_valid_reg, fwd_valid_next;
    logic [BIN_W-1:0]     fwd_bin_reg, fwd_bin_next;
    logic [CW-1:0]        fwd_val_reg, fwd_val_next;
    logic [CW-1:0]        total_reg, total_next;
    logic [BIN_COUNT-1:0] msg_valid_reg, msg_valid_next;
    logic [BIN_COUNT-1:0] life_valid_reg, life_valid_next;
    logic [BIN_W-1:0]     mrg_idx_reg, mrg_idx_next;
    logic                 mrg_wr_valid_reg, mrg_wr_valid_next;
    logic [BIN_W-1:0]     mrg_wr_addr_reg, mrg_wr_addr_next;
    logic [BIN_W-1:0]     qry_bin_reg, qry_bin_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg, out_kind_next;
    logic [OUT_W-1:0]     out_count_reg, out_count_next;

    logic                 out_free;
    logic                 ld_data, ld_end, ld_qry, ld_qzero, ld_abort;
    logic                 mrg_rd, mrg_finish, qry_done;

    logic [BIN_W-1:0]     msg_rd_addr, life_rd_addr;
    logic [CW-1:0]        msg_rd_data, life_rd_data;
    logic [CW-1:0]        w_cur, w_new;
    logic [CW-1:0]        mrg_life, mrg_msg, mrg_sum;

    assign out_free = !out_valid_reg || m_tready;

    // Control decode per state
    always_comb
    begin
        ld_data    = 1'b0;
        ld_end     = 1'b0;
        ld_qry     = 1'b0;
        ld_qzero   = 1'b0;
        ld_abort   = 1'b0;
        mrg_rd     = 1'b0;
        mrg_finish = 1'b0;
        qry_done   = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                if (q_valid)
                begin
                    case (q_item.op)
                        OP_DATA:       ld_data  = 1'b1;
                        OP_ABORT:      ld_abort = !w_valid_reg;
                        OP_END:        ld_end   = !w_valid_reg && out_free;
                        OP_QUERY:      ld_qry   = out_free;
                        OP_QUERY_ZERO: ld_qzero = out_free;
                        default:       ld_abort = !w_valid_reg;
                    endcase
                end
            end
            ST_QUERY:      qry_done   = 1'b1;
            ST_MERGE:      mrg_rd     = 1'b1;
            ST_MERGE_LAST: mrg_finish = 1'b1;
            default:       ;
        endcase
    end

    assign q_pop = ld_data || ld_end || ld_qry || ld_qzero || ld_abort;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (ld_end)
                begin
                    state_next = ST_MERGE;
                end
                else if (ld_qry)
                begin
                    state_next = ST_QUERY;
                end
            end
            ST_QUERY: state_next = ST_RUN;
            ST_MERGE:
            begin
                if (mrg_idx_reg == BIN_W'(BIN_COUNT - 1))
                begin
                    state_next = ST_MERGE_LAST;
                end
            end
            ST_MERGE_LAST: state_next = ST_RUN;
            default:       state_next = ST_RUN;
        endcase
    end

    assign msg_rd_addr  = mrg_rd ? mrg_idx_reg : q_item.bin;
    assign life_rd_addr = mrg_rd ? mrg_idx_reg : q_item.bin;

    // Bypass the previous write: the RAM returns old data for a same-cycle hit
    assign w_cur = (fwd_valid_reg && (fwd_bin_reg == w_bin_reg)) ? fwd_val_reg :
                   (msg_valid_reg[w_bin_reg] ? msg_rd_data : '0);
    assign w_new = sat_add(w_cur, CW'(1));

    assign mrg_life = life_valid_reg[mrg_wr_addr_reg] ? life_rd_data : '0;
    assign mrg_msg  = msg_valid_reg[mrg_wr_addr_reg] ? msg_rd_data : '0;
    assign mrg_sum  = sat_add(mrg_life, mrg_msg);

    pch_ram #(
        .WIDTH (CW),
        .DEPTH (BIN_COUNT)
    ) u_msg_ram (
        .clk     (clk),
        .wr_en   (w_valid_reg),
        .wr_addr (w_bin_reg),
        .wr_data (w_new),
        .rd_addr (msg_rd_addr),
        .rd_data (msg_rd_data)
    );

    pch_ram #(
        .WIDTH (CW),
        .DEPTH (BIN_COUNT)
    ) u_life_ram (
        .clk     (clk),
        .wr_en   (mrg_wr_valid_reg),
        .wr_addr (mrg_wr_addr_reg),
        .wr_data (mrg_sum),
        .rd_addr (life_rd_addr),
        .rd_data (life_rd_data)
    );

    always_comb
    begin
        w_valid_next      = ld_data;
        w_bin_next        = q_item.bin;
        fwd_valid_next    = w_valid_reg;
        fwd_bin_next      = w_bin_reg;
        fwd_val_next      = w_new;

        total_next = total_reg;
        if (ld_data)
        begin
            total_next = sat_add(total_reg, CW'(1));
        end
        else if (ld_end || ld_abort)
        begin
            total_next = '0;
        end

        msg_valid_next = msg_valid_reg;
        if (w_valid_reg)
        begin
            msg_valid_next[w_bin_reg] = 1'b1;
        end
        if (ld_abort || mrg_finish)
        begin
            msg_valid_next = '0;
        end

        life_valid_next = life_valid_reg;
        if (mrg_wr_valid_reg)
        begin
            life_valid_next[mrg_wr_addr_reg] = 1'b1;
        end

        mrg_idx_next = mrg_idx_reg;
        if (ld_end)
        begin
            mrg_idx_next = '0;
        end
        else if (mrg_rd)
        begin
            mrg_idx_next = mrg_idx_reg + 1'b1;
        end
        mrg_wr_valid_next = mrg_rd;
        mrg_wr_addr_next  = mrg_idx_reg;

        qry_bin_next = ld_qry ? q_item.bin : qry_bin_reg;

        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_count_next = out_count_reg;
        if (ld_end)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = RESP_MESSAGE;
            out_count_next = to_out(total_reg);
        end
        else if (ld_qzero)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = RESP_LIFETIME;
            out_count_next = '0;
        end
        else if (qry_done)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = RESP_LIFETIME;
            out_count_next = life_valid_reg[qry_bin_reg] ? to_out(life_rd_data) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_RUN;
            w_valid_reg      <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            total_reg        <= '0;
            msg_valid_reg    <= '0;
            life_valid_reg   <= '0;
            mrg_wr_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            w_valid_reg      <= w_valid_next;
            fwd_valid_reg    <= fwd_valid_next;
            total_reg        <= total_next;
            msg_valid_reg    <= msg_valid_next;
            life_valid_reg   <= life_valid_next;
            mrg_wr_valid_reg <= mrg_wr_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_bin_reg       <= w_bin_next;
        fwd_bin_reg     <= fwd_bin_next;
        fwd_val_reg     <= fwd_val_next;
        mrg_idx_reg     <= mrg_idx_next;
        mrg_wr_addr_reg <= mrg_wr_addr_next;
        qry_bin_reg     <= qry_bin_next;
        out_kind_reg    <= out_kind_next;
        out_count_reg   <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_count_reg;
    assign m_tuser  = out_kind_reg;

endmodule
`default_nettype wire

### rtl/printable_char_histogram.sv
`timescale 1ns / 1ps
`default_nettype none
// Data bytes: one per cycle sustained while no query or merge holds the unit;
//   pipelined message RAM read-modify-write, bypass for back-to-back same-bin hits.
// Query: the result is registered from the lifetime RAM read (registered RAM read).
// End of message: result in the cycle after dequeue; the 95-bin merge into the
//   lifetime RAM then holds the execution unit until the last bin is written.
// Reset: all counts read as zero at once through per-bin valid flops; no sweep.
// ----------------------------------------------------------------------------
// printable_char_histogram: per-message and lifetime character histogram
// Classifier and queue in front of an execution unit with two count memories.
// ----------------------------------------------------------------------------
module printable_char_histogram #(
    parameter int COUNT_WIDTH = pch_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = pch_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // byte_value[7:0]
    input  wire logic [1:0]               s_tuser,   // kind[1:0]
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [pch_pkg::OUT_W-1:0]     m_tdata,   // count_value[47:0]
    output logic [0:0]                    m_tuser    // response_kind
);
    import pch_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    op_item_t push_item;
    op_item_t head_item;

    pch_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    pch_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_item (head_item)
    );

    pch_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(q_pop) || $past(q_pop, 2)))
        else $error("result without a dequeued operation");

endmodule
`default_nettype wire
